// File: design/fault_code_blink_sequencer_unit_assert.svh
// assertion macros for the fault code blink sequencer
`ifndef FAULT_CODE_BLINK_SEQUENCER_UNIT_ASSERT_SVH
`define FAULT_CODE_BLINK_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FCB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("fcb assertion failed");

// next-cycle implication, checked out of reset
`define FCB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("fcb assertion failed");

`endif

// File: design/fcb_pkg.sv
// shared constants and blink rom for the fault code blink sequencer
`default_nettype none

package fcb_pkg;

  localparam int unsigned CODE_DIGITS_DEF = 4;
  localparam int unsigned FAULT_CODE_W    = 16;
  localparam int unsigned DIGIT_POS_W     = 3;
  localparam int unsigned NIBBLE_W        = 4;
  localparam int unsigned ELEM_W          = 3;
  localparam int unsigned TICKS_W         = 2;
  localparam int unsigned ROM_W           = 8;
  localparam int unsigned ROM_LEN_LSB     = 5;

  localparam logic [TICKS_W-1:0] DASH_TICKS = 2'd3;
  localparam logic [TICKS_W-1:0] DOT_TICKS  = 2'd1;
  localparam logic [TICKS_W-1:0] GAP_TICKS  = 2'd3;

  // bits 7..5 element count, bits 4..0 element kinds lsb first, 1 = dash
  function automatic logic [ROM_W-1:0] blink_rom(input logic [NIBBLE_W-1:0] nib);
    logic [ROM_W-1:0] word;
    case (nib)
      4'h0:    word = 8'hBF;
      4'h1:    word = 8'hBE;
      4'h2:    word = 8'hBC;
      4'h3:    word = 8'hB8;
      4'h4:    word = 8'hB0;
      4'h5:    word = 8'hA0;
      4'h6:    word = 8'hA1;
      4'h7:    word = 8'hA3;
      4'h8:    word = 8'hA7;
      4'h9:    word = 8'hAF;
      4'hA:    word = 8'h42;
      4'hB:    word = 8'h81;
      4'hC:    word = 8'h85;
      4'hD:    word = 8'h61;
      4'hE:    word = 8'h20;
      default: word = 8'h84;
    endcase
    return word;
  endfunction

endpackage

`default_nettype wire

// File: design/fcb_if.sv
// tick input and blink result channel interfaces
`default_nettype none

interface fcb_tick_if;
  import fcb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [FAULT_CODE_W-1:0] fault_code;

  modport source (output valid, output fault_code, input ready);
  modport sink (input valid, input fault_code, output ready);
endinterface

interface fcb_blink_if;
  import fcb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   led_on;
  logic [DIGIT_POS_W-1:0] digit_position;

  modport source (output valid, output led_on, output digit_position, input ready);
  modport sink (input valid, input led_on, input digit_position, output ready);
endinterface

`default_nettype wire

// File: design/fault_code_blink_sequencer_unit.sv
// top level of the fault code blink sequencer
`default_nettype none
`include "fault_code_blink_sequencer_unit_assert.svh"

// Each tick beat carries the current 16-bit fault code and produces exactly one
// result beat holding the LED level and the digit being shown after that tick.
// While idle (digit_position equals CODE_DIGITS, low 3 bits) the code is
// sampled every tick; a zero code keeps the block idle. A nonzero code is
// latched and blinked as CODE_DIGITS hex digits, most significant first; digits
// above bit 15 show as zero. Each digit's rom word gives up to five elements:
// a dash is lit for three ticks, a dot for one, each followed by one dark tick,
// and every digit ends with a gap tick, three dark ticks and an advance tick.
// Rate: one tick beat per clock cycle. The whole tick update is a single pass
// of logic from the sequencer state registers into the result register, and
// a new beat is taken while the previous result waits, as long as the result
// register is empty or being drained in the same cycle.
module fault_code_blink_sequencer_unit #(
  parameter int unsigned CODE_DIGITS = fcb_pkg::CODE_DIGITS_DEF
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  fcb_tick_if.sink      tick_i,
  fcb_blink_if.source   blink_o
);
  import fcb_pkg::*;

  localparam int unsigned DigW = $clog2(CODE_DIGITS + 1);
  localparam logic [DigW-1:0] IdleDigit = DigW'(CODE_DIGITS);
  localparam logic [DigW-1:0] LastDigit = DigW'(CODE_DIGITS - 1);

  // sequencer state
  logic [FAULT_CODE_W-1:0] shown_code_q, shown_code_d;
  logic [DigW-1:0]         digit_q, digit_d;
  logic [ELEM_W-1:0]       elem_q, elem_d;
  logic [TICKS_W-1:0]      ticks_q, ticks_d;
  logic                    lit_q, lit_d;

  // result register
  logic                    out_valid_q;
  logic                    led_on_q;
  logic [DIGIT_POS_W-1:0]  digit_pos_q;

  logic                    accept;
  logic                    idle;
  logic [FAULT_CODE_W-1:0] code_eff;
  logic [DigW-1:0]         digit_eff;
  logic [ELEM_W-1:0]       elem_eff;
  logic [DigW-1:0]         rev;
  logic [DigW+1:0]         rev_ext;
  logic [NIBBLE_W-1:0]     nib;
  logic [ROM_W-1:0]        pat;
  logic [ELEM_W-1:0]       len;
  logic [DigW+2:0]         digit_ext;

  // result register frees up when empty or drained this cycle
  assign tick_i.ready = !out_valid_q || blink_o.ready;
  assign accept       = tick_i.valid && tick_i.ready;

  assign idle      = (digit_q >= IdleDigit);
  // an idle tick with a nonzero code starts at the first element of digit 0
  assign code_eff  = idle ? tick_i.fault_code : shown_code_q;
  assign digit_eff = idle ? '0 : digit_q;
  assign elem_eff  = idle ? '0 : elem_q;

  // digit position counted from the least significant nibble
  assign rev     = LastDigit - digit_eff;
  assign rev_ext = {2'b00, rev};
  assign nib     = (rev_ext[DigW+1:2] == '0) ?
                   code_eff[{rev_ext[1:0], 2'b00} +: NIBBLE_W] : '0;
  assign pat     = blink_rom(nib);
  assign len     = pat[ROM_LEN_LSB +: ELEM_W];

  always_comb begin
    shown_code_d = shown_code_q;
    digit_d      = digit_q;
    elem_d       = elem_q;
    ticks_d      = ticks_q;
    lit_d        = lit_q;

    if (idle) begin
      shown_code_d = tick_i.fault_code;
    end

    if (!idle || (tick_i.fault_code != '0)) begin
      digit_d = digit_eff;
      elem_d  = elem_eff;
      if (ticks_q == '0) begin
        if (elem_eff == len) begin
          // gap tick loads the dark countdown
          ticks_d = GAP_TICKS;
          elem_d  = elem_eff + 1'b1;
        end else if (elem_eff > len) begin
          // advance tick moves to the next digit, past the last one is idle
          digit_d = digit_eff + 1'b1;
          elem_d  = '0;
        end else begin
          // element start lights the led
          ticks_d = pat[elem_eff] ? DASH_TICKS : DOT_TICKS;
          elem_d  = elem_eff + 1'b1;
          lit_d   = 1'b1;
        end
      end else begin
        if (ticks_q == 2'd1) begin
          lit_d = 1'b0;
        end
        ticks_d = ticks_q - 1'b1;
      end
    end
  end

  // digit position keeps only its low bits for wide digit counts
  assign digit_ext = {3'b000, digit_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_code_q <= '0;
      digit_q      <= IdleDigit;
      elem_q       <= '0;
      ticks_q      <= '0;
      lit_q        <= 1'b0;
    end else if (accept) begin
      shown_code_q <= shown_code_d;
      digit_q      <= digit_d;
      elem_q       <= elem_d;
      ticks_q      <= ticks_d;
      lit_q        <= lit_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_i.ready) begin
      out_valid_q <= tick_i.valid;
    end
  end

  // result payload, loaded with each accepted tick
  always_ff @(posedge clk_i) begin
    if (accept) begin
      led_on_q    <= lit_d;
      digit_pos_q <= digit_ext[DIGIT_POS_W-1:0];
    end
  end

  assign blink_o.valid          = out_valid_q;
  assign blink_o.led_on         = led_on_q;
  assign blink_o.digit_position = digit_pos_q;

  // the led is always dark while idle
  `FCB_ASSERT_IMP(a_idle_dark, clk_i, rst_ni, idle, !lit_q)
  // idle state carries no pending countdown or element
  `FCB_ASSERT_IMP(a_idle_clean, clk_i, rst_ni, idle, (ticks_q == '0) && (elem_q == '0))
  // a countdown tick never moves to another digit
  `FCB_ASSERT_NXT(a_count_holds_digit, clk_i, rst_ni, accept && (ticks_q != '0),
                  digit_q == $past(digit_q))

endmodule

`default_nettype wire
